>>> design/fbrf_pkg.sv
// Shared types, widths and constants for the filtered byte ring FIFO.
`timescale 1ns / 1ps

package fbrf_pkg;

    // Ring geometry (DEPTH must be a power of two).
    localparam int DEPTH     = 256;
    localparam int MAX_BURST = 64;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = ADDR_W + 1;             // pointers run modulo 2*DEPTH
    localparam int BURST_W = $clog2(MAX_BURST + 1);

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 9;
    localparam int SEL_W  = 3;
    localparam int CMD_W  = 2;

    // Widest of pointer and count, for comparisons
    localparam int CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;

    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_ONE  = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_FOUR = 8'h34;
    localparam logic [BYTE_W-1:0] RAW_ONE   = 8'h01;
    localparam logic [BYTE_W-1:0] RAW_FOUR  = 8'h04;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX      = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_CONSUME = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_PEEK = 2'b10
    } t_state;

endpackage

>>> design/fbrf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module fbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/filtered_byte_ring_fifo_unit.sv
// Top level of the filtered byte ring FIFO: command decode, pointers and peek streaming.
`timescale 1ns / 1ps

// Filtered byte ring FIFO.
// Input channel (i_valid / o_stall) carries one command per transaction:
//   received byte - a digit '1'..'4' or raw 1..4 sets the selection and queues
//                   the ASCII digit; a full ring drops it, other bytes do nothing.
//   peek          - streams up to min(count, MAX_BURST, fill) oldest bytes,
//                   leaving them in the ring.
//   consume       - drops min(count, fill) oldest bytes.
// Output channel (o_valid / i_stall) carries one result transaction per
// received byte, consume, no-op command or empty peek, and one per byte for a peek.
// A single-result command shows its result in the cycle after acceptance.
// A peek passes its first byte through the state register, the registered read of
// the ring RAM and the output register, then streams one byte per cycle while
// the receiver does not stall; once the last byte has been loaded the block
// returns to idle and can take commands again; other commands keep it in idle.
// Reset (synchronous, active low) empties the ring and clears the selection;
// the ring RAM contents are not cleared and no clearing pass is needed.
// A stalled receiver holds the output register; the block then stops taking
// commands and pauses a peek without losing the byte already read.
module filtered_byte_ring_fifo_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [fbrf_pkg::CMD_W-1:0]     i_cmd,
    input  logic [fbrf_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic [fbrf_pkg::CNT_W-1:0]     i_count,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [fbrf_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                           o_out_last,
    output logic [fbrf_pkg::CNT_W-1:0]     o_out_count,
    output logic                           o_accepted,
    output logic [fbrf_pkg::SEL_W-1:0]     o_selection,
    output logic [fbrf_pkg::CNT_W-1:0]     o_fill_level
);

    localparam int PW = fbrf_pkg::PTR_W;
    localparam int AW = fbrf_pkg::ADDR_W;
    localparam int BW = fbrf_pkg::BURST_W;
    localparam int CW = fbrf_pkg::CNT_W;
    localparam int MW = fbrf_pkg::CMP_W;

    // Control state
    fbrf_pkg::t_state r_state, n_state;
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [fbrf_pkg::SEL_W-1:0] r_sel, n_sel;
    logic             r_o_valid, n_o_valid;
    // Peek sequencing
    logic [BW-1:0]    r_n, n_n;             // bytes to stream
    logic [BW-1:0]    r_issued, n_issued;   // reads issued so far
    logic             r_pend, n_pend;       // RAM read data waiting for the output
    logic             r_pend_last, n_pend_last;
    // Output payload
    logic [fbrf_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic [CW-1:0]    r_out_count, n_out_count;
    logic             r_accepted, n_accepted;
    logic [fbrf_pkg::SEL_W-1:0] r_out_sel, n_out_sel;
    logic [CW-1:0]    r_out_fill, n_out_fill;

    // Combinational helpers
    fbrf_pkg::t_cmd   cmd;
    logic [PW-1:0]    fill;
    logic             out_free;
    logic             in_acc;
    logic             is_ascii, is_raw, dig_ok, room, push;
    logic [fbrf_pkg::SEL_W-1:0] rx_sel;
    logic [fbrf_pkg::BYTE_W-1:0] digit;
    logic [PW-1:0]    cons_n;
    logic [BW-1:0]    peek_lim, peek_n;
    logic             ld, issue;
    logic [PW-1:0]    rd_addr_ptr;
    logic [fbrf_pkg::BYTE_W-1:0] ram_rdata;

    assign cmd      = fbrf_pkg::t_cmd'(i_cmd);
    assign fill     = r_wr_ptr - r_rd_ptr;
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = !((r_state == fbrf_pkg::S_IDLE) && out_free);
    assign in_acc   = i_valid && !o_stall;

    // Digit filter: ASCII '1'..'4' or raw 1..4
    assign is_ascii = (i_rx_byte >= fbrf_pkg::CHAR_ONE) && (i_rx_byte <= fbrf_pkg::CHAR_FOUR);
    assign is_raw   = (i_rx_byte >= fbrf_pkg::RAW_ONE) && (i_rx_byte <= fbrf_pkg::RAW_FOUR);
    assign dig_ok   = is_ascii || is_raw;
    assign rx_sel   = is_ascii ? fbrf_pkg::SEL_W'(i_rx_byte - fbrf_pkg::CHAR_ZERO)
                               : fbrf_pkg::SEL_W'(i_rx_byte);
    assign digit    = fbrf_pkg::CHAR_ZERO + fbrf_pkg::BYTE_W'(rx_sel);
    assign room     = fill < PW'(fbrf_pkg::DEPTH);
    assign push     = in_acc && (cmd == fbrf_pkg::CMD_RX) && dig_ok && room;

    // Consume clamps to the fill; peek saturates at the burst limit and the fill
    assign cons_n   = (MW'(i_count) > MW'(fill)) ? fill : PW'(i_count);
    assign peek_lim = (i_count > CW'(fbrf_pkg::MAX_BURST)) ? BW'(fbrf_pkg::MAX_BURST)
                                                          : BW'(i_count);
    assign peek_n   = (MW'(fill) < MW'(peek_lim)) ? BW'(fill) : peek_lim;

    // Peek streaming: move pending read data out, then refill the read slot
    assign ld    = (r_state == fbrf_pkg::S_PEEK) && r_pend && out_free;
    assign issue = (r_state == fbrf_pkg::S_PEEK) && (r_issued != r_n) && (!r_pend || ld);
    assign rd_addr_ptr = r_rd_ptr + PW'(r_issued);

    fbrf_ram #(
        .WIDTH (fbrf_pkg::BYTE_W),
        .DEPTH (fbrf_pkg::DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_wr_ptr[AW-1:0]),
        .i_wdata (digit),
        .i_re    (issue),
        .i_raddr (rd_addr_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_sel       = r_sel;
        n_o_valid   = r_o_valid && i_stall;   // drop once taken
        n_n         = r_n;
        n_issued    = r_issued;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_count = r_out_count;
        n_accepted  = r_accepted;
        n_out_sel   = r_out_sel;
        n_out_fill  = r_out_fill;

        unique case (r_state)
            fbrf_pkg::S_IDLE: begin
                if (in_acc) begin
                    // single status result unless a peek has bytes to stream
                    n_o_valid   = 1'b1;
                    n_out_byte  = '0;
                    n_out_last  = 1'b1;
                    n_out_count = '0;
                    n_accepted  = 1'b0;
                    n_out_sel   = r_sel;
                    n_out_fill  = CW'(fill);
                    case (cmd)
                        fbrf_pkg::CMD_RX: begin
                            if (dig_ok) begin
                                n_sel     = rx_sel;
                                n_out_sel = rx_sel;
                            end
                            if (push) begin
                                n_wr_ptr   = r_wr_ptr + PW'(1);
                                n_accepted = 1'b1;
                                n_out_fill = CW'(fill + PW'(1));
                            end
                        end
                        fbrf_pkg::CMD_PEEK: begin
                            if (peek_n != '0) begin
                                n_o_valid   = 1'b0;
                                n_state     = fbrf_pkg::S_PEEK;
                                n_n         = peek_n;
                                n_issued    = '0;
                                n_pend      = 1'b0;
                                n_pend_last = 1'b0;
                            end
                        end
                        fbrf_pkg::CMD_CONSUME: begin
                            n_rd_ptr    = r_rd_ptr + cons_n;
                            n_out_count = CW'(cons_n);
                            n_out_fill  = CW'(fill - cons_n);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fbrf_pkg::S_PEEK: begin
                if (ld) begin
                    n_o_valid   = 1'b1;
                    n_out_byte  = ram_rdata;
                    n_out_last  = r_pend_last;
                    n_out_count = CW'(r_n);
                    n_accepted  = 1'b0;
                    n_out_sel   = r_sel;
                    n_out_fill  = CW'(fill);
                    if (r_pend_last) begin
                        n_state = fbrf_pkg::S_IDLE;
                    end
                end
                if (issue) begin
                    n_issued    = r_issued + BW'(1);
                    n_pend_last = (r_issued + BW'(1)) == r_n;
                end
                n_pend = issue || (r_pend && !ld);
            end
            default: begin
                n_state = fbrf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fbrf_pkg::S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_sel       <= '0;
            r_o_valid   <= 1'b0;
            r_n         <= '0;
            r_issued    <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_sel       <= n_sel;
            r_o_valid   <= n_o_valid;
            r_n         <= n_n;
            r_issued    <= n_issued;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
        end
    end

    // Result payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_count <= n_out_count;
        r_accepted  <= n_accepted;
        r_out_sel   <= n_out_sel;
        r_out_fill  <= n_out_fill;
    end

    assign o_valid      = r_o_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;
    assign o_out_count  = r_out_count;
    assign o_accepted   = r_accepted;
    assign o_selection  = r_out_sel;
    assign o_fill_level = r_out_fill;

`ifndef SYNTHESIS
    // Occupancy never exceeds the ring depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= PW'(fbrf_pkg::DEPTH))
        else $error("ring fill exceeds depth");

    // No command is taken while a peek streams
    a_peek_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbrf_pkg::S_PEEK) |-> o_stall)
        else $error("command accepted during peek");

    // Never issue more reads than the peek asked for
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fbrf_pkg::S_PEEK) |-> (r_issued <= r_n))
        else $error("peek over-read");

    // A pending byte blocked by a stall is kept for the next cycle
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !ld && (r_state == fbrf_pkg::S_PEEK)) |=> r_pend)
        else $error("pending peek byte lost");

    // Pointers move only on an accepted command
    a_ptr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> ($stable(r_wr_ptr) && $stable(r_rd_ptr)))
        else $error("pointer moved without a command");
`endif

endmodule

>>> test/tb_filtered_byte_ring_fifo_unit.sv
// Self-checking testbench for the filtered byte ring FIFO unit.
`timescale 1ns / 1ps

module tb_filtered_byte_ring_fifo_unit;

    localparam int HALF_PERIOD = 10;
    localparam int QUIET_LIMIT = 1000;   // cycles with no transaction before giving up
    localparam int SETTLE_CYCLES = fbrf_pkg::MAX_BURST + 8;

    typedef struct packed {
        logic [fbrf_pkg::BYTE_W-1:0] out_byte;
        logic                        out_last;
        logic [fbrf_pkg::CNT_W-1:0]  out_count;
        logic                        accepted;
        logic [fbrf_pkg::SEL_W-1:0]  selection;
        logic [fbrf_pkg::CNT_W-1:0]  fill_level;
    } t_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [fbrf_pkg::CMD_W-1:0]  i_cmd = fbrf_pkg::CMD_RX;
    logic [fbrf_pkg::BYTE_W-1:0] i_rx_byte = '0;
    logic [fbrf_pkg::CNT_W-1:0]  i_count = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [fbrf_pkg::BYTE_W-1:0] o_out_byte;
    logic                        o_out_last;
    logic [fbrf_pkg::CNT_W-1:0]  o_out_count;
    logic                        o_accepted;
    logic [fbrf_pkg::SEL_W-1:0]  o_selection;
    logic [fbrf_pkg::CNT_W-1:0]  o_fill_level;

    // Shadow copy of the ring, its pointers and the selection
    logic [fbrf_pkg::BYTE_W-1:0] ring_bytes [fbrf_pkg::DEPTH];
    logic [fbrf_pkg::PTR_W-1:0]  ring_wr = '0;
    logic [fbrf_pkg::PTR_W-1:0]  ring_rd = '0;
    logic [fbrf_pkg::SEL_W-1:0]  ring_sel = '0;

    t_result            awaited_results [$];
    t_result            oldest;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;
    bit                 idle_on = 1'b1;

    filtered_byte_ring_fifo_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_rx_byte    (i_rx_byte),
        .i_count      (i_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_out_count  (o_out_count),
        .o_accepted   (o_accepted),
        .o_selection  (o_selection),
        .o_fill_level (o_fill_level)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Work out the results of one accepted command and advance the shadow state.
    task automatic apply_command(input fbrf_pkg::t_cmd cmd,
                                 input logic [fbrf_pkg::BYTE_W-1:0] rx,
                                 input logic [fbrf_pkg::CNT_W-1:0] cnt);
        logic [fbrf_pkg::CNT_W-1:0]  fill;
        logic [fbrf_pkg::CNT_W-1:0]  lim;
        logic [fbrf_pkg::CNT_W-1:0]  n;
        logic [fbrf_pkg::BYTE_W-1:0] digit;
        logic [fbrf_pkg::PTR_W-1:0]  idx;
        logic                        is_digit;
        t_result                     r;
        fill = ring_wr - ring_rd;
        r = '0;
        r.out_last = 1'b1;
        case (cmd)
            fbrf_pkg::CMD_RX: begin
                is_digit = 1'b0;
                digit = '0;
                if (rx >= fbrf_pkg::CHAR_ONE && rx <= fbrf_pkg::CHAR_FOUR) begin
                    ring_sel = fbrf_pkg::SEL_W'(rx - fbrf_pkg::CHAR_ZERO);
                    digit = rx;
                    is_digit = 1'b1;
                end else if (rx >= fbrf_pkg::RAW_ONE && rx <= fbrf_pkg::RAW_FOUR) begin
                    ring_sel = rx[fbrf_pkg::SEL_W-1:0];
                    digit = fbrf_pkg::CHAR_ZERO + rx;
                    is_digit = 1'b1;
                end
                // A full ring drops the digit but keeps the new selection
                if (is_digit && fill < fbrf_pkg::DEPTH) begin
                    ring_bytes[ring_wr[fbrf_pkg::ADDR_W-1:0]] = digit;
                    ring_wr = ring_wr + 1'b1;
                    r.accepted = 1'b1;
                end
            end
            fbrf_pkg::CMD_PEEK: begin
                lim = (cnt > fbrf_pkg::MAX_BURST) ? fbrf_pkg::CNT_W'(fbrf_pkg::MAX_BURST)
                                                  : cnt;
                n = (fill < lim) ? fill : lim;
                if (n != 0) begin
                    for (int i = 0; i < n; i++) begin
                        idx = ring_rd + fbrf_pkg::PTR_W'(i);
                        r.out_byte = ring_bytes[idx[fbrf_pkg::ADDR_W-1:0]];
                        r.out_last = (i == n - 1);
                        r.out_count = n;
                        r.selection = ring_sel;
                        r.fill_level = fill;
                        awaited_results.push_back(r);
                    end
                    return;
                end
            end
            fbrf_pkg::CMD_CONSUME: begin
                n = (cnt > fill) ? fill : cnt;
                ring_rd = ring_rd + n;
                r.out_count = n;
            end
            default: ;
        endcase
        r.selection = ring_sel;
        r.fill_level = ring_wr - ring_rd;
        awaited_results.push_back(r);
    endtask

    // Offer one command, idling beforehand at random, and hold it until taken.
    task automatic send_item(input fbrf_pkg::t_cmd cmd,
                             input logic [fbrf_pkg::BYTE_W-1:0] rx,
                             input logic [fbrf_pkg::CNT_W-1:0] cnt);
        while (idle_on && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_cmd     <= cmd;
        i_rx_byte <= rx;
        i_count   <= cnt;
        do @(posedge i_clk); while (o_stall);
        apply_command(cmd, rx, cnt);
    endtask

    // Drop valid and hold off until every awaited result has arrived.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    function automatic logic [fbrf_pkg::BYTE_W-1:0] random_digit();
        logic [fbrf_pkg::BYTE_W-1:0] base;
        base = $urandom_range(0, 1) ? fbrf_pkg::CHAR_ONE : fbrf_pkg::RAW_ONE;
        return base + fbrf_pkg::BYTE_W'($urandom_range(0, 3));
    endfunction

    task automatic test_empty_ring();
        send_item(fbrf_pkg::CMD_PEEK, 8'h00, 9'd0);
        send_item(fbrf_pkg::CMD_PEEK, 8'hff, 9'd5);
        send_item(fbrf_pkg::CMD_CONSUME, 8'h00, 9'd3);
        send_item(fbrf_pkg::CMD_NONE, 8'h31, 9'd7);
        // Bytes outside both digit ranges leave everything alone
        send_item(fbrf_pkg::CMD_RX, 8'h00, 9'd0);
        send_item(fbrf_pkg::CMD_RX, 8'hff, 9'd256);
        send_item(fbrf_pkg::CMD_RX, 8'h05, 9'd0);
        send_item(fbrf_pkg::CMD_RX, fbrf_pkg::CHAR_ZERO, 9'd0);
        send_item(fbrf_pkg::CMD_RX, 8'h35, 9'd255);
    endtask

    task automatic test_digits();
        for (int d = 0; d < 4; d++)
            send_item(fbrf_pkg::CMD_RX, fbrf_pkg::CHAR_ONE + fbrf_pkg::BYTE_W'(d), 9'd0);
        for (int d = 0; d < 4; d++)
            send_item(fbrf_pkg::CMD_RX, fbrf_pkg::RAW_FOUR - fbrf_pkg::BYTE_W'(d), 9'd0);
        send_item(fbrf_pkg::CMD_PEEK, 8'h00, 9'd0);      // data present, nothing asked
        send_item(fbrf_pkg::CMD_PEEK, 8'h00, 9'd3);
        send_item(fbrf_pkg::CMD_PEEK, 8'h00, 9'd256);    // saturates, limited by the fill
        send_item(fbrf_pkg::CMD_PEEK, 8'hff, 9'd255);
        send_item(fbrf_pkg::CMD_CONSUME, 8'h00, 9'd2);
        send_item(fbrf_pkg::CMD_NONE, 8'h00, 9'd256);
        send_item(fbrf_pkg::CMD_CONSUME, 8'h00, 9'd256); // clamped to the fill
        send_item(fbrf_pkg::CMD_PEEK, 8'h00, 9'd1);
    endtask

    // Fill past the burst limit with no idling and stream the longest peek.
    task automatic test_burst_limit();
        idle_on = 1'b0;
        repeat (fbrf_pkg::MAX_BURST + 2)
            send_item(fbrf_pkg::CMD_RX, random_digit(), 9'($urandom_range(0, 256)));
        send_item(fbrf_pkg::CMD_PEEK, 8'h00, 9'd256);    // saturates at the burst limit
        send_item(fbrf_pkg::CMD_PEEK, 8'h00, 9'd64);
        send_item(fbrf_pkg::CMD_CONSUME, 8'h00, 9'd256);
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int roll;
        logic [fbrf_pkg::CNT_W-1:0] cnt;
        for (int k = 0; k < 20; k++) begin
            if (k == 10) wait_for_drain();
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                send_item(fbrf_pkg::CMD_RX, random_digit(), 9'($urandom_range(0, 256)));
            end else if (roll < 50) begin
                send_item(fbrf_pkg::CMD_RX, 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 256)));
            end else if (roll < 75) begin
                cnt = ($urandom_range(0, 4) != 0) ? 9'($urandom_range(0, 70))
                                                   : 9'($urandom_range(0, 256));
                send_item(fbrf_pkg::CMD_PEEK, 8'($urandom_range(0, 255)), cnt);
            end else if (roll < 97) begin
                cnt = ($urandom_range(0, 4) != 0) ? 9'($urandom_range(0, 6))
                                                   : 9'($urandom_range(0, 256));
                send_item(fbrf_pkg::CMD_CONSUME, 8'($urandom_range(0, 255)), cnt);
            end else begin
                send_item(fbrf_pkg::CMD_NONE, 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 256)));
            end
        end
    endtask

    task automatic check_field(input string field_name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name,
                     want, got);
            mismatches++;
        end
    endtask

    // Compare every result transaction with the oldest awaited one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %0d count %0d",
                         $time, o_out_byte, o_out_count);
                mismatches++;
            end else begin
                oldest = awaited_results.pop_front();
                check_field("out_byte", oldest.out_byte, o_out_byte);
                check_field("out_last", oldest.out_last, o_out_last);
                check_field("out_count", oldest.out_count, o_out_count);
                check_field("accepted", oldest.accepted, o_accepted);
                check_field("selection", oldest.selection, o_selection);
                check_field("fill_level", oldest.fill_level, o_fill_level);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 7);
        end
    end

    // Watchdog: give up after a long run of cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_ring();
        test_digits();
        test_burst_limit();
        test_random_traffic();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
design/fbrf_pkg.sv
design/fbrf_ram.sv
design/filtered_byte_ring_fifo_unit.sv
test/tb_filtered_byte_ring_fifo_unit.sv
